@@ sv/gpb_pkg.sv @@
package gpb_pkg;

   // Command codes carried in the action field
   typedef enum logic [2:0] {
      ACT_WR_LEVEL = 3'd0,
      ACT_RD_LEVEL = 3'd1,
      ACT_SET_FUNC = 3'd2,
      ACT_RD_FUNC  = 3'd3,
      ACT_SET_PULL = 3'd4,
      ACT_RD_PULL  = 3'd5,
      ACT_SET_DRV  = 3'd6,
      ACT_RD_DRV   = 3'd7
   } action_type;

   // Width class of the addressed field inside its word
   typedef enum logic [1:0] {
      FLD_LEVEL = 2'd0,
      FLD_FUNC  = 2'd1,
      FLD_TWO   = 2'd2
   } field_kind_type;

   // Word offsets inside one port's group of nine words
   localparam logic [3:0] K_FUNC  = 4'd0;
   localparam logic [3:0] K_DATA  = 4'd4;
   localparam logic [3:0] K_DRIVE = 4'd5;
   localparam logic [3:0] K_PULL  = 4'd7;

   localparam int         WORDS_PER_PORT = 9;
   localparam int         PORT_PINS      = 32;
   localparam logic [7:0] WORDS_MULT     = 8'(WORDS_PER_PORT);

   localparam logic [2:0] LEVEL_MASK = 3'b001;
   localparam logic [2:0] FUNC_MASK  = 3'b111;
   localparam logic [2:0] TWO_MASK   = 3'b011;

   typedef struct packed {
      logic [2:0] action;
      logic [8:0] pin;
      logic [3:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] read_value;
      logic       pin_out_of_range;
   } rsp_type;

   // Decoded command as it travels down the pipeline
   typedef struct packed {
      logic           is_write;
      logic           out_of_range;
      field_kind_type kind;
      logic [4:0]     shift;
      logic [2:0]     wr_field;
   } cmd_type;

   function automatic logic [2:0] field_mask(input field_kind_type kind);
      logic [2:0] m;
      unique case (kind)
         FLD_LEVEL: m = LEVEL_MASK;
         FLD_FUNC:  m = FUNC_MASK;
         FLD_TWO:   m = TWO_MASK;
         default:   m = 3'b000;
      endcase
      return m;
   endfunction

endpackage

@@ sv/gpb_decode.sv @@
module gpb_decode #(
   parameter int NUM_PINS = 288,
   parameter int IDX_W    = 7
) (
   input  gpb_pkg::req_type    req,
   output gpb_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]    word_idx
);
   import gpb_pkg::*;

   localparam logic [9:0] PIN_LIMIT = 10'(NUM_PINS);

   action_type act;
   logic [4:0] bit_pos;
   logic [3:0] k;
   logic [7:0] idx_full;

   always_comb begin
      act     = action_type'(req.action);
      bit_pos = req.pin[4:0];

      cmd.is_write     = ~req.action[0];
      cmd.out_of_range = ({1'b0, req.pin} >= PIN_LIMIT);

      unique case (act)
         ACT_WR_LEVEL, ACT_RD_LEVEL: begin
            cmd.kind     = FLD_LEVEL;
            k            = K_DATA;
            cmd.shift    = bit_pos;
            cmd.wr_field = {2'b00, |req.value};
         end
         ACT_SET_FUNC, ACT_RD_FUNC: begin
            cmd.kind     = FLD_FUNC;
            k            = K_FUNC + {2'b00, bit_pos[4:3]};
            cmd.shift    = {bit_pos[2:0], 2'b00};
            cmd.wr_field = req.value[2:0];
         end
         ACT_SET_PULL, ACT_RD_PULL: begin
            cmd.kind     = FLD_TWO;
            k            = K_PULL + {3'b000, bit_pos[4]};
            cmd.shift    = {bit_pos[3:0], 1'b0};
            cmd.wr_field = {1'b0, req.value[1:0]};
         end
         ACT_SET_DRV, ACT_RD_DRV: begin
            cmd.kind     = FLD_TWO;
            k            = K_DRIVE + {3'b000, bit_pos[4]};
            cmd.shift    = {bit_pos[3:0], 1'b0};
            cmd.wr_field = {1'b0, req.value[1:0]};
         end
         default: begin
            cmd.kind     = FLD_LEVEL;
            k            = K_DATA;
            cmd.shift    = bit_pos;
            cmd.wr_field = 3'b000;
         end
      endcase

      // port number times nine plus word offset; at most 143
      idx_full = {4'b0000, req.pin[8:5]} * WORDS_MULT + {4'b0000, k};
      word_idx = cmd.out_of_range ? '0 : idx_full[IDX_W-1:0];
   end

endmodule

@@ sv/gpb_store.sv @@
module gpb_store #(
   parameter int DEPTH = 81,
   parameter int IDX_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [31:0]       wr_word,
   output logic [31:0]       rd_word
);

   logic [31:0]      mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [31:0]      mem_rd_ff;
   logic             hit_ff;
   logic             fwd_ff;
   logic [31:0]      fwd_word_ff;
   logic             fwd_in;

   // a read issued in the cycle its word is written back takes the new word
   assign fwd_in = rd_en & wr_en & (rd_idx == wr_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_word;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_idx];
         fwd_word_ff <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
         fwd_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_idx];
            fwd_ff <= fwd_in;
         end
      end
   end

   // never-written words read as zero
   assign rd_word = fwd_ff ? fwd_word_ff : (hit_ff ? mem_rd_ff : 32'h0);

endmodule

@@ sv/gpio_pin_config_bank_unit.sv @@
// Per-pin access to a GPIO port controller's register bank: NUM_PINS pins in
// ports of 32, each port owning nine 32-bit words (four function-select words,
// one data word, two drive words, two pull words). Every request transaction
// names a pin and an action and yields exactly one response transaction; set
// actions read, modify and write back only that pin's field, read actions return
// it, and a pin at or above NUM_PINS leaves the bank untouched and answers zero
// with pin_out_of_range set. One request is taken every clock cycle while the
// receiver keeps up; a response is presented once its request has passed
// through the update stage (command and registered word read, loaded on
// acceptance) and the output register (field update, loaded as the stage
// drains), the limit being the single read-modify-write of one word per command.
// The bank is an 81-word memory at the default size with a valid bit per word,
// so it reads as zero straight out of reset and needs no clearing pass.
module gpio_pin_config_bank_unit #(
   parameter int NUM_PINS = 288
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gpb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gpb_pkg::rsp_type rsp_data
);
   import gpb_pkg::*;

   localparam int NUM_PORTS = (NUM_PINS + PORT_PINS - 1) / PORT_PINS;
   localparam int DEPTH     = NUM_PORTS * WORDS_PER_PORT;
   localparam int IDX_W     = $clog2(DEPTH);

   // decode of the incoming transaction
   cmd_type          dec_cmd;
   logic [IDX_W-1:0] dec_idx;

   // update stage: command whose word is being read back
   logic             s1_valid_ff;
   logic             s1_valid_in;
   cmd_type          s1_cmd_ff;
   logic [IDX_W-1:0] s1_idx_ff;

   // response register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   logic             accept;
   logic             rsp_free;
   logic             s1_advance;
   logic             store_wr_en;
   logic [31:0]      cur_word;
   logic [31:0]      new_word;
   logic [2:0]       fmask;
   logic [31:0]      shifted;

   gpb_decode #(
      .NUM_PINS (NUM_PINS),
      .IDX_W    (IDX_W)
   ) u_decode (
      .req      (req_data),
      .cmd      (dec_cmd),
      .word_idx (dec_idx)
   );

   // Flow control: the update stage drains whenever the response register is
   // empty or being taken, so a waiting response never blocks a new request
   // unless the update stage is also holding one.
   assign rsp_free    = ~rsp_valid_ff | ~rsp_stall;
   assign s1_advance  = s1_valid_ff & rsp_free;
   assign req_stall   = s1_valid_ff & ~rsp_free;
   assign accept      = req_valid & ~req_stall;

   // write back only in-range set actions, at the moment they leave the stage
   assign store_wr_en = s1_advance & s1_cmd_ff.is_write & ~s1_cmd_ff.out_of_range;

   gpb_store #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (dec_idx),
      .wr_en   (store_wr_en),
      .wr_idx  (s1_idx_ff),
      .wr_word (new_word),
      .rd_word (cur_word)
   );

   // Field update and extraction: clear the field, merge the new code in,
   // and pull the old code out for read actions.
   always_comb begin
      fmask    = field_mask(s1_cmd_ff.kind);
      new_word = (cur_word & ~(32'(fmask) << s1_cmd_ff.shift))
               | (32'(s1_cmd_ff.wr_field) << s1_cmd_ff.shift);
      shifted  = cur_word >> s1_cmd_ff.shift;

      rsp_data_in.pin_out_of_range = s1_cmd_ff.out_of_range;
      if (s1_cmd_ff.is_write || s1_cmd_ff.out_of_range) begin
         rsp_data_in.read_value = 3'b000;
      end else begin
         rsp_data_in.read_value = shifted[2:0] & fmask;
      end
   end

   always_comb begin
      s1_valid_in  = accept | (s1_valid_ff & ~s1_advance);
      rsp_valid_in = s1_advance | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load on accept / advance, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= dec_cmd;
         s1_idx_ff <= dec_idx;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction did not reach the update stage");

   a_advance_fills_rsp : assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("transaction left the update stage without a response");

   a_oor_reads_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.pin_out_of_range) |-> (rsp_data_ff.read_value == 3'b000))
      else $error("out-of-range response carries a nonzero field");

   a_no_oor_write : assert property (@(posedge clock) disable iff (reset)
      store_wr_en |-> (s1_valid_ff && !s1_cmd_ff.out_of_range && rsp_free))
      else $error("write-back issued for an ignored or stalled transaction");

endmodule

@@ bench/gpio_pin_config_bank_unit_tb.sv @@
import gpb_pkg::*;

// Shadow copy of the port register bank plus the queue of responses still owed
class pin_bank_scoreboard #(int PIN_COUNT = 288);
   localparam int WORD_COUNT = ((PIN_COUNT + 31) / 32) * WORDS_PER_PORT;

   logic [31:0] bank [WORD_COUNT];
   req_type     cmd_q[$];
   rsp_type     owed_q[$];
   int          mismatches;
   int          compared;
   int          far_pins;
   int          action_seen [8];

   function new();
      foreach (bank[i]) bank[i] = '0;
      foreach (action_seen[i]) action_seen[i] = 0;
      mismatches = 0;
      compared   = 0;
      far_pins   = 0;
   endfunction

   // Apply one command to the shadow bank and return the response it earns
   function rsp_type apply_command(req_type c);
      rsp_type r;
      int      port_base;
      int      bitpos;
      int      idx;
      int      sh;
      r = '0;
      if (c.pin >= PIN_COUNT) begin
         r.pin_out_of_range = 1'b1;
         return r;
      end
      port_base = (c.pin / PORT_PINS) * WORDS_PER_PORT;
      bitpos    = c.pin % PORT_PINS;
      case (c.action)
         ACT_WR_LEVEL: begin
            bank[port_base + K_DATA][bitpos] = (c.value != 4'd0);
         end
         ACT_RD_LEVEL: begin
            r.read_value = {2'b00, bank[port_base + K_DATA][bitpos]};
         end
         ACT_SET_FUNC, ACT_RD_FUNC: begin
            idx = port_base + K_FUNC + bitpos / 8;
            sh  = (bitpos % 8) * 4;
            if (c.action == ACT_SET_FUNC) bank[idx][sh +: 3] = c.value[2:0];
            else r.read_value = bank[idx][sh +: 3];
         end
         ACT_SET_PULL, ACT_RD_PULL, ACT_SET_DRV, ACT_RD_DRV: begin
            if (c.action == ACT_SET_PULL || c.action == ACT_RD_PULL)
               idx = port_base + K_PULL + bitpos / 16;
            else
               idx = port_base + K_DRIVE + bitpos / 16;
            sh = (bitpos % 16) * 2;
            if (c.action == ACT_SET_PULL || c.action == ACT_SET_DRV)
               bank[idx][sh +: 2] = c.value[1:0];
            else
               r.read_value = {1'b0, bank[idx][sh +: 2]};
         end
         default: ;
      endcase
      return r;
   endfunction

   function void note_command(req_type c);
      cmd_q.push_back(c);
      owed_q.push_back(apply_command(c));
      action_seen[c.action]++;
      if (c.pin >= PIN_COUNT) far_pins++;
   endfunction

   task flag_mismatch(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
   endtask

   task check_response(rsp_type got);
      rsp_type want;
      req_type c;
      compared++;
      if (owed_q.size() == 0) begin
         flag_mismatch($sformatf("response %p arrived with nothing owed", got));
         return;
      end
      want = owed_q.pop_front();
      c    = cmd_q.pop_front();
      if (got.read_value !== want.read_value)
         flag_mismatch($sformatf("read_value %0d, wanted %0d (action %0d pin %0d value %0d)",
                                 got.read_value, want.read_value, c.action, c.pin, c.value));
      if (got.pin_out_of_range !== want.pin_out_of_range)
         flag_mismatch($sformatf("pin_out_of_range %0b, wanted %0b (action %0d pin %0d)",
                                 got.pin_out_of_range, want.pin_out_of_range,
                                 c.action, c.pin));
   endtask
endclass

module gpio_pin_config_bank_unit_tb;

   localparam int PIN_COUNT    = 288;
   localparam int RANDOM_ITEMS = 1650;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Idle chance in percent, shared by both sides; zero during the quiet stretch
   int idle_pct  = 21;
   // Cycles of forced receiver hold-off still to run
   int hold_left = 0;

   logic [8:0] hot_pins [8];

   pin_bank_scoreboard #(PIN_COUNT) board;

   gpio_pin_config_bank_unit #(.NUM_PINS(PIN_COUNT)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: generous against the slowest legal run
   initial begin
      #2_000_000;
      $display("gpio_pin_config_bank_unit: mismatch");
      $finish;
   end

   function automatic req_type make_cmd(action_type a, int pin, int value);
      req_type c;
      c.action = a;
      c.pin    = 9'(pin);
      c.value  = 4'(value);
      return c;
   endfunction

   // Most commands land on a small pool of hot pins so that reads see earlier
   // writes; the rest roam the whole bank or fall past the last pin.
   function automatic req_type random_command();
      req_type c;
      int      roll;
      roll     = $urandom_range(99);
      c.action = 3'($urandom_range(7));
      c.value  = 4'($urandom_range(15));
      if (roll < 8)
         c.pin = 9'($urandom_range(511, PIN_COUNT));
      else if (roll < 65)
         c.pin = hot_pins[$urandom_range(7)];
      else
         c.pin = 9'($urandom_range(PIN_COUNT - 1));
      // Rotate the pool now and then to spread coverage across all ports
      if ($urandom_range(31) == 0) hot_pins[$urandom_range(7)] = 9'($urandom_range(PIN_COUNT - 1));
      return c;
   endfunction

   // Offer one transaction, starting and ending at a falling edge. Hold the
   // payload steady while the block stalls.
   task automatic send_command(req_type c);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_command(c);
      @(negedge clock);
   endtask

   // Field extremes, every action, masking of wide values and pins past the bank
   task automatic run_directed();
      send_command(make_cmd(ACT_SET_FUNC, 0, 15));    // bit 3 of the field must stay clear
      send_command(make_cmd(ACT_RD_FUNC, 0, 0));
      send_command(make_cmd(ACT_SET_FUNC, 1, 8));     // masks to zero
      send_command(make_cmd(ACT_RD_FUNC, 1, 0));
      send_command(make_cmd(ACT_SET_FUNC, 7, 5));
      send_command(make_cmd(ACT_RD_FUNC, 7, 0));
      send_command(make_cmd(ACT_WR_LEVEL, PIN_COUNT - 1, 2)); // any nonzero sets the bit
      send_command(make_cmd(ACT_RD_LEVEL, PIN_COUNT - 1, 0));
      send_command(make_cmd(ACT_WR_LEVEL, PIN_COUNT - 1, 0));
      send_command(make_cmd(ACT_RD_LEVEL, PIN_COUNT - 1, 15));
      send_command(make_cmd(ACT_SET_PULL, 31, 15));   // masks to two bits
      send_command(make_cmd(ACT_RD_PULL, 31, 0));
      send_command(make_cmd(ACT_SET_DRV, 16, 6));
      send_command(make_cmd(ACT_SET_DRV, 15, 1));
      send_command(make_cmd(ACT_RD_DRV, 16, 0));
      send_command(make_cmd(ACT_RD_DRV, 15, 0));
      send_command(make_cmd(ACT_SET_PULL, 256, 3));
      send_command(make_cmd(ACT_RD_PULL, 256, 0));
      send_command(make_cmd(ACT_RD_PULL, PIN_COUNT - 1, 0)); // never written: zero
      send_command(make_cmd(ACT_SET_FUNC, PIN_COUNT, 7));    // ignored write
      send_command(make_cmd(ACT_RD_FUNC, PIN_COUNT, 0));
      send_command(make_cmd(ACT_WR_LEVEL, 511, 15));
      send_command(make_cmd(ACT_RD_LEVEL, 511, 0));
      send_command(make_cmd(ACT_RD_DRV, 300, 9));
   endtask

   // Receiver: stall at random, or for the whole of a forced hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   // Compare every response transaction at the edge that accepts it
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      board     = new();
      foreach (hot_pins[i]) hot_pins[i] = 9'($urandom_range(PIN_COUNT - 1));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Hold the receiver off long enough to back the block up into its input
         if (n == 400) hold_left = 150;
         // Drop all idling for a stretch so back-to-back traffic is exercised
         idle_pct = (n >= 900 && n < 1150) ? 0 : 21;
         send_command(random_command());
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed response, then keep watching for strays
      while (board.owed_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d commands (%0d to pins past the bank), %0d responses compared",
               board.compared + board.owed_q.size(), board.far_pins, board.compared);
      $display("Per action: wl %0d rl %0d sf %0d rf %0d sp %0d rp %0d sd %0d rd %0d",
               board.action_seen[ACT_WR_LEVEL], board.action_seen[ACT_RD_LEVEL],
               board.action_seen[ACT_SET_FUNC], board.action_seen[ACT_RD_FUNC],
               board.action_seen[ACT_SET_PULL], board.action_seen[ACT_RD_PULL],
               board.action_seen[ACT_SET_DRV], board.action_seen[ACT_RD_DRV]);
      if (board.mismatches == 0) begin
         $display("gpio_pin_config_bank_unit: match");
      end else begin
         $display("gpio_pin_config_bank_unit: mismatch");
      end
      $finish;
   end

endmodule
